// ===== design/bf3x3_pkg.sv =====
package bf3x3_pkg;

   localparam int MAX_LINE    = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int COL_W       = $clog2(MAX_LINE);
   localparam int DIM_W       = 11;
   localparam int PIX_W       = 8;
   localparam int COLSUM_W    = PIX_W + 2;
   localparam int SUM_W       = PIX_W + 4;

   // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
   localparam int RECIP       = 7282;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = SUM_W + RECIP_W;

   typedef enum logic {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic have;
      logic at_left;
      logic at_right;
      logic at_top;
      logic at_bottom;
      logic last;
   } pos_type;

endpackage

// ===== design/box_filter_3x3_top.sv =====
// 3x3 box (mean) filter for 8-bit grey pixels streamed in raster order.
// Input channel req_*: one pixel per transfer; req_pad_item = 1 marks a drain
// item whose pixel is ignored. After the W*H pixels of a frame, send W+1 pad
// items to flush the last results. Result channel rsp_*: the neighborhood sum
// divided by nine, truncated; rsp_frame_last marks the final pixel of a frame.
// Pixels outside the image count as zero.
// The result for raster position n is produced by the transfer of item n+W+1;
// it passes the input stage and then the result register, which feeds rsp_*.
// One item per clock sustained while no result is held by rsp_stall: each item
// passes through one input stage (line store read) and one result register, and
// each line store takes at most one read and one write in every cycle.
// csr_*: writes line_width (index 0) and frame_height (index 1); a write
// restarts the frame position. Write only while the block is idle.
// Reset (synchronous) empties both stages, restarts the frame and restores
// width 640 and height 480; line store contents are left as they are.
// When rsp_stall is high the result holds; the block still takes a new item
// unless its input stage also holds an item with a result, in which case req_stall rises.
module box_filter_3x3_top import bf3x3_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_pad_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_smoothed,
   output logic             rsp_frame_last,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [DIM_W-1:0] eff_w, eff_h;
   logic [COL_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic             accept;

   logic [DIM_W-1:0] col_inc;
   logic [DIM_W-1:0] row_next;
   logic [DIM_W-1:0] cur_row;
   logic             col_is0, wrap, restart;
   pos_type          pos_in;
   logic [PIX_W-1:0] pix_in;

   logic             s1_valid_ff;
   pos_type          s1_pos_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [PIX_W-1:0] prev_rd_ff, older_rd_ff;
   logic             byp_ff, byp_in;
   logic [PIX_W-1:0] byp_top_ff, byp_mid_ff;
   logic             s1_adv;

   logic [PIX_W-1:0] row_prev_mem  [MAX_LINE];
   logic [PIX_W-1:0] row_older_mem [MAX_LINE];

   logic [PIX_W-1:0] top_cur, mid_cur;
   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] colv   [3][3];
   logic [COLSUM_W-1:0] col_sum [3];
   logic [SUM_W-1:0]    sum;
   logic [PROD_W-1:0]   prod;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_smoothed_ff;
   logic             rsp_frame_last_ff;

   // effective frame size
   always_comb begin
      if (width_ff == '0) begin
         eff_w = DIM_W'(1);
      end else if (int'(width_ff) > MAX_LINE) begin
         eff_w = DIM_W'(MAX_LINE);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = DIM_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         eff_h = DIM_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign s1_adv    = s1_valid_ff && (!s1_pos_ff.have || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   // position of the window center relative to the incoming pixel
   always_comb begin
      col_is0          = (col_ff == '0);
      cur_row          = col_is0 ? row_ff - DIM_W'(2) : row_ff - DIM_W'(1);
      pos_in.have      = (row_ff >= DIM_W'(2)) || ((row_ff == DIM_W'(1)) && !col_is0);
      pos_in.at_left   = col_is0 ? (eff_w == DIM_W'(1)) : (col_ff == COL_W'(1));
      pos_in.at_right  = col_is0;
      pos_in.at_top    = (cur_row == '0);
      pos_in.at_bottom = (cur_row == eff_h - DIM_W'(1));
      pos_in.last      = pos_in.have && pos_in.at_bottom && col_is0;

      pix_in   = (req_pad_item || (row_ff >= eff_h)) ? '0 : req_pixel;

      col_inc  = DIM_W'(col_ff) + DIM_W'(1);
      wrap     = (col_inc >= eff_w);
      row_next = row_ff + DIM_W'(wrap);
      restart  = pos_in.last || ({1'b0, row_next} > ({1'b0, eff_h} + (DIM_W + 1)'(1)));
      col_in   = (restart || wrap) ? '0 : col_inc[COL_W-1:0];
      row_in   = restart ? '0 : row_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_WIDTH:   width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line stores: read when an item is taken, written when it leaves stage 1
   assign top_cur = byp_ff ? byp_top_ff : older_rd_ff;
   assign mid_cur = byp_ff ? byp_mid_ff : prev_rd_ff;
   // consecutive items share a column when the line is one pixel wide or the frame position restarts
   assign byp_in  = s1_adv && (s1_col_ff == col_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_rd_ff  <= row_prev_mem[col_ff];
         older_rd_ff <= row_older_mem[col_ff];
      end
      if (s1_adv) begin
         row_prev_mem[s1_col_ff]  <= s1_pix_ff;
         row_older_mem[s1_col_ff] <= mid_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= pix_in;
         s1_col_ff  <= col_ff;
         s1_pos_ff  <= pos_in;
         byp_ff     <= byp_in;
         byp_top_ff <= mid_cur;
         byp_mid_ff <= s1_pix_ff;
      end
   end

   // window: column 0 oldest, row 0 top
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[j][i] <= '0;
            end
         end
      end else if (s1_adv) begin
         win_ff[0]    <= win_ff[1];
         win_ff[1]    <= win_ff[2];
         win_ff[2][0] <= top_cur;
         win_ff[2][1] <= mid_cur;
         win_ff[2][2] <= s1_pix_ff;
      end
   end

   always_comb begin
      colv[0]    = win_ff[1];
      colv[1]    = win_ff[2];
      colv[2][0] = top_cur;
      colv[2][1] = mid_cur;
      colv[2][2] = s1_pix_ff;
      for (int j = 0; j < 3; j++) begin
         col_sum[j] = COLSUM_W'(colv[j][1])
                    + (s1_pos_ff.at_top    ? '0 : COLSUM_W'(colv[j][0]))
                    + (s1_pos_ff.at_bottom ? '0 : COLSUM_W'(colv[j][2]));
      end
      sum  = (s1_pos_ff.at_left  ? '0 : SUM_W'(col_sum[0]))
           + SUM_W'(col_sum[1])
           + (s1_pos_ff.at_right ? '0 : SUM_W'(col_sum[2]));
      prod = PROD_W'(sum) * PROD_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_pos_ff.have) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_pos_ff.have) begin
         rsp_smoothed_ff   <= prod[RECIP_SHIFT +: PIX_W];
         rsp_frame_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_smoothed   = rsp_smoothed_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

endmodule

// ===== design/bf3x3_checker.sv =====
module bf3x3_checker import bf3x3_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [PIX_W-1:0] rsp_smoothed,
   input logic             rsp_frame_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_smoothed)
                                 && $stable(rsp_frame_last))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // the input side backs up only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

endmodule

bind box_filter_3x3_top bf3x3_checker u_bf3x3_checker (.*);
